// ===== src/assert_macros.svh =====
// Assertion macros shared by the transcoder RTL files.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define TSU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define TSU_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define TSU_ASSERT(lbl, clk, rstn, prop, msg)
`define TSU_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== src/tsu_pkg.sv =====
// Shared types, constants and the UTF-8 encode function of the transcoder.
// No dependencies; imported by every module of the block.
package tsu_pkg;

    // Most result bytes one input byte can cause
    localparam int MaxBytes = 6;

    // Byte-order mark, first and second byte
    localparam logic [7:0] C_BOM_HI = 8'hFE;
    localparam logic [7:0] C_BOM_LO = 8'hFF;

    // Top six bits of a high (D800..DBFF) and a low (DC00..DFFF) surrogate
    localparam logic [5:0] C_HI_TAG = 6'b110110;
    localparam logic [5:0] C_LO_TAG = 6'b110111;

    // Offset of the supplementary planes
    localparam logic [20:0] C_SUPP_BASE = 21'h10000;

    // Decoding phase of the current string
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_WIDE   = 2'd2,
        PH_NARROW = 2'd3
    } t_phase;

    // Encoded form of one code point
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } t_utf8;

    // All results of one input byte, handed from the transcoder to the serializer
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] data;
        logic [2:0]               cnt;    // 1..6
        logic                     empty;  // end marker without data
        logic                     done;   // closes the string
    } t_burst;

    // Encode one code point as 1 to 4 UTF-8 bytes, first byte in slot 0
    function automatic t_utf8 utf8_enc(input logic [20:0] cp);
        t_utf8 r;
        r.bytes = '0;
        if (cp < 21'h80) begin
            r.bytes[0] = cp[7:0];
            r.len      = 3'd1;
        end else if (cp < 21'h800) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.len      = 3'd2;
        end else if (cp < 21'h10000) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.len      = 3'd3;
        end else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.len      = 3'd4;
        end
        return r;
    endfunction

endpackage

// ===== src/tsu_xcode.sv =====
// Input register, string state and combinational transcode of one byte.
// Depends on tsu_pkg and assert_macros.svh; feeds tsu_serial with a t_burst.
`include "assert_macros.svh"

module tsu_xcode
    import tsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output logic       o_valid,
    input  logic       i_ready,
    output t_burst     o_burst
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // String state
    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       r_held_valid, n_held_valid;
    logic [9:0] r_pend, n_pend;
    logic       r_pend_valid, n_pend_valid;

    // Up to two code points per byte
    logic [20:0] w_cp0, w_cp1;
    logic        w_v0, w_v1;
    logic [15:0] w_unit;
    logic        w_is_hi, w_is_lo, w_unit_emit;
    t_utf8       w_e0, w_e1;
    logic [2:0]  w_len0, w_len1, w_total, w_j;
    logic        w_advance, w_has_out;

    assign w_unit  = {r_held, r_in_byte};
    assign w_is_hi = (w_unit[15:10] == C_HI_TAG);
    assign w_is_lo = (w_unit[15:10] == C_LO_TAG);
    // A fresh high surrogate is emitted at once only when the string ends here
    assign w_unit_emit = !w_is_hi || r_in_end;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (r_in_end) begin
            n_phase = PH_FIRST;
        end else begin
            case (r_phase)
                PH_FIRST: begin
                    n_phase = PH_SECOND;
                end
                PH_SECOND: begin
                    if (r_held == C_BOM_HI && r_in_byte == C_BOM_LO) begin
                        n_phase = PH_WIDE;
                    end else begin
                        n_phase = PH_NARROW;
                    end
                end
                PH_WIDE: begin
                    n_phase = PH_WIDE;
                end
                PH_NARROW: begin
                    n_phase = PH_NARROW;
                end
                default: begin
                    n_phase = PH_FIRST;
                end
            endcase
        end
    end

    // Code points to emit and next held/pending state
    always_comb begin
        w_cp0        = '0;
        w_cp1        = '0;
        w_v0         = 1'b0;
        w_v1         = 1'b0;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        case (r_phase)
            PH_FIRST: begin
                if (r_in_end) begin
                    w_cp0 = {13'd0, r_in_byte};
                    w_v0  = 1'b1;
                end else begin
                    n_held       = r_in_byte;
                    n_held_valid = 1'b1;
                end
            end
            PH_SECOND: begin
                if (!(r_held == C_BOM_HI && r_in_byte == C_BOM_LO)) begin
                    w_cp0 = {13'd0, r_held};
                    w_v0  = 1'b1;
                    w_cp1 = {13'd0, r_in_byte};
                    w_v1  = 1'b1;
                end
                n_held       = '0;
                n_held_valid = 1'b0;
            end
            PH_WIDE: begin
                if (r_held_valid) begin
                    n_held       = '0;
                    n_held_valid = 1'b0;
                    if (r_pend_valid && w_is_lo) begin
                        // Join the surrogate pair
                        w_cp0        = C_SUPP_BASE + {1'b0, r_pend, w_unit[9:0]};
                        w_v0         = 1'b1;
                        n_pend       = '0;
                        n_pend_valid = 1'b0;
                    end else begin
                        if (r_pend_valid) begin
                            // Unpaired high surrogate goes out first
                            w_cp0 = {5'd0, C_HI_TAG, r_pend};
                            w_v0  = 1'b1;
                            w_cp1 = {5'd0, w_unit};
                            w_v1  = w_unit_emit;
                        end else begin
                            w_cp0 = {5'd0, w_unit};
                            w_v0  = w_unit_emit;
                        end
                        n_pend       = w_is_hi ? w_unit[9:0] : 10'd0;
                        n_pend_valid = w_is_hi;
                    end
                end else begin
                    n_held       = r_in_byte;
                    n_held_valid = 1'b1;
                    // Flush a waiting high surrogate at string end
                    if (r_in_end && r_pend_valid) begin
                        w_cp0 = {5'd0, C_HI_TAG, r_pend};
                        w_v0  = 1'b1;
                    end
                end
            end
            PH_NARROW: begin
                w_cp0 = {13'd0, r_in_byte};
                w_v0  = 1'b1;
            end
            default: begin
                w_v0 = 1'b0;
            end
        endcase
        // String end drops an odd byte and clears everything
        if (r_in_end) begin
            n_held       = '0;
            n_held_valid = 1'b0;
            n_pend       = '0;
            n_pend_valid = 1'b0;
        end
    end

    // Encode both code points and pack them back to back
    always_comb begin
        w_e0    = utf8_enc(w_cp0);
        w_e1    = utf8_enc(w_cp1);
        w_len0  = w_v0 ? w_e0.len : 3'd0;
        w_len1  = w_v1 ? w_e1.len : 3'd0;
        w_total = w_len0 + w_len1;
        w_j     = '0;
        o_burst = '0;
        for (int i = 0; i < MaxBytes; i++) begin
            w_j = 3'(i) - w_len0;
            if (3'(i) < w_len0) begin
                o_burst.data[i] = w_e0.bytes[i[1:0]];
            end else if (w_j < w_len1) begin
                o_burst.data[i] = w_e1.bytes[w_j[1:0]];
            end
        end
        if (w_total == 3'd0) begin
            o_burst.cnt   = 3'd1;
            o_burst.empty = 1'b1;
        end else begin
            o_burst.cnt   = (w_total > 3'(MaxBytes)) ? 3'(MaxBytes) : w_total;
            o_burst.empty = 1'b0;
        end
        o_burst.done = r_in_end;
    end

    // Items without results retire without waiting for the serializer
    assign w_has_out = (w_len0 != 3'd0) || (w_len1 != 3'd0) || r_in_end;
    assign o_valid   = r_in_valid && w_has_out;
    assign w_advance = r_in_valid && (!w_has_out || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    // Input register: load on every accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
            r_in_end  <= i_end;
        end
    end

    // State registers: advance once per retired item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FIRST;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_pend       <= '0;
            r_pend_valid <= 1'b0;
        end else if (w_advance) begin
            r_phase      <= n_phase;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_pend       <= n_pend;
            r_pend_valid <= n_pend_valid;
        end
    end

    `TSU_ASSERT(a_held_phase, i_clk, i_rst_n,
        r_held_valid |-> (r_phase == PH_SECOND || r_phase == PH_WIDE), "held byte outside phase")
    `TSU_ASSERT(a_pend_phase, i_clk, i_rst_n,
        r_pend_valid |-> (r_phase == PH_WIDE), "pending surrogate outside UTF-16 phase")
    `TSU_ASSERT(a_end_clears, i_clk, i_rst_n,
        (w_advance && r_in_end) |=> (r_phase == PH_FIRST && !r_pend_valid), "state kept over end")

endmodule

// ===== src/tsu_serial.sv =====
// Result buffer sending each burst a byte per cycle unless stalled.
// Depends on tsu_pkg and assert_macros.svh; fed by tsu_xcode.
`include "assert_macros.svh"

module tsu_serial
    import tsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_burst     i_burst,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data,   // out_byte
    output logic [1:0] o_user,   // [0] byte_valid, [1] run_last
    output logic       o_last    // string_done
);

    logic                     r_busy;
    logic [MaxBytes-1:0][7:0] r_data;
    logic [2:0]               r_cnt;
    logic [2:0]               r_idx;
    logic                     r_empty;
    logic                     r_done;
    logic                     w_tail, w_load;

    assign w_tail  = (r_idx == r_cnt - 3'd1);
    assign o_ready = !r_busy || (i_ready && w_tail);
    assign w_load  = i_valid && o_ready;

    // Drive the current byte
    assign o_valid = r_busy;
    assign o_data  = r_empty ? 8'd0 : r_data[r_idx];
    assign o_user  = {w_tail, !r_empty};
    assign o_last  = r_done && w_tail;

    // Load a new burst or advance through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            if (w_tail) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data  <= i_burst.data;
            r_cnt   <= i_burst.cnt;
            r_empty <= i_burst.empty;
            r_done  <= i_burst.done;
        end
    end

    `TSU_ASSERT(a_idx_range, i_clk, i_rst_n,
        r_busy |-> (r_idx < r_cnt), "byte index past burst")
    `TSU_ASSERT(a_empty_single, i_clk, i_rst_n,
        (r_busy && r_empty) |-> (r_cnt == 3'd1), "end marker with data bytes")
    `TSU_ASSERT(a_drain, i_clk, i_rst_n,
        (r_busy && i_ready && w_tail && !i_valid) |=> !r_busy, "buffer not released")

endmodule

// ===== src/text_string_to_utf8_core.sv =====
// Top level of the text string to UTF-8 transcoder.
// Depends on tsu_pkg, tsu_xcode and tsu_serial.
//
// Takes one byte of a text string per transfer (tlast on the final byte) and
// sends UTF-8 bytes. A string that opens with FE FF is read as big-endian
// UTF-16 with surrogate pairing; unpaired surrogates go out as three bytes and
// an odd trailing byte is dropped. Otherwise each byte is a code point 0..255.
// A string whose end yields no byte closes with one marker transfer that has
// byte_valid low. An input byte passes an input register and a combinational
// transcode into a result buffer. While the receiver is ready, the buffer sends
// one byte per cycle and a new byte can be taken every cycle as long as none
// causes more than one result; one that causes none retires without waiting.
// A byte with N results (up to 6) holds the output until all N are sent.
module text_string_to_utf8_core
    import tsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // string_end
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_axis_tuser,   // [0] byte_valid, [1] run_last
    output logic       o_m_axis_tlast    // string_done
);

    logic   w_burst_valid;
    logic   w_burst_ready;
    t_burst w_burst;

    // Transcode one byte per transfer
    tsu_xcode u_xcode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_end   (i_s_axis_tlast),
        .o_valid (w_burst_valid),
        .i_ready (w_burst_ready),
        .o_burst (w_burst)
    );

    // Send results a byte at a time
    tsu_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_burst_valid),
        .o_ready (w_burst_ready),
        .i_burst (w_burst),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_user  (o_m_axis_tuser),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for text_string_to_utf8_core.
// Needs tsu_pkg and the transcoder RTL; predicts every UTF-8 byte from the input
// string bytes and compares each output transfer in order.
`timescale 1ns / 100ps

module tb;
    import tsu_pkg::*;

    localparam int          RandomItems = 360;
    localparam int          QuietLimit  = 1000;  // cycles with no transfer on either side
    localparam int          HoldOffLen  = 100;   // long receiver hold-off
    localparam int          HoldOffAt   = 150;   // input count that triggers it
    localparam int          CalmFrom    = 250;   // input count range with no idling
    localparam int          CalmTo      = 330;
    localparam int          TailCycles  = 16;
    localparam int          MaxPrinted  = 50;

    localparam logic [15:0] SUR_HI_MIN  = 16'hD800;
    localparam logic [15:0] SUR_HI_MAX  = 16'hDBFF;
    localparam logic [15:0] SUR_LO_MIN  = 16'hDC00;
    localparam logic [15:0] SUR_LO_MAX  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    // One string byte to send; sync holds it back until all results are in
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       sync;
    } t_text_byte;

    // One expected output transfer
    typedef struct packed {
        logic [7:0] data;
        logic       ok;
        logic       last;
        logic       done;
    } t_utf8_beat;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data  = 8'h00;
    logic       s_last  = 1'b0;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_data;
    logic [1:0] m_user;
    logic       m_last;
    logic       in_fire;
    logic       out_fire;
    logic       in_taken = 1'b0;

    t_text_byte text_bytes_q[$];
    t_utf8_beat utf8_due_q[$];
    logic [7:0] cp_bytes_q[$];
    logic [7:0] raw_q[$];
    logic       sync_next = 1'b0;

    // Decoder state of the predictor
    t_phase     dec_phase;
    logic [7:0] held_b;
    logic       held_ok;
    logic [9:0] hi_sur;
    logic       hi_ok;

    int         err_count = 0;
    int         in_count  = 0;
    int         out_count = 0;
    int         hold_cnt  = 0;
    logic       hold_used = 1'b0;
    int         quiet_cycles = 0;

    text_string_to_utf8_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // [7:0] in_byte
        .i_s_axis_tlast  (s_last),    // string_end
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),    // [7:0] out_byte
        .o_m_axis_tuser  (m_user),    // [0] byte_valid, [1] run_last
        .o_m_axis_tlast  (m_last)     // string_done
    );

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Print one mismatch line (first few only) and count it
    task automatic report_mismatch(input string msg);
        if (err_count < MaxPrinted)
            $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    // Queue a byte of the string under test
    task automatic put_text(input logic [7:0] b, input logic fin);
        t_text_byte t;
        t.data    = b;
        t.fin     = fin;
        t.sync    = sync_next;
        sync_next = 1'b0;
        text_bytes_q.insert(text_bytes_q.size(), t);
    endtask

    task automatic put_unit(input logic [15:0] u);
        put_text(u[15:8], 1'b0);
        put_text(u[7:0], 1'b0);
    endtask

    // Append one byte to the string being built
    task automatic add_raw(input logic [7:0] b);
        raw_q.insert(raw_q.size(), b);
    endtask

    // Append one predicted UTF-8 byte of the current input byte
    task automatic add_cp_byte(input logic [7:0] b);
        cp_bytes_q.insert(cp_bytes_q.size(), b);
    endtask

    // Append one expected output transfer
    task automatic add_beat(input t_utf8_beat b);
        utf8_due_q.insert(utf8_due_q.size(), b);
    endtask

    task automatic clear_decoder();
        dec_phase = PH_FIRST;
        held_b    = 8'h00;
        held_ok   = 1'b0;
        hi_sur    = 10'h000;
        hi_ok     = 1'b0;
    endtask

    // Append the UTF-8 form of one code point: lead byte, then 6-bit tails
    task automatic emit_cp(input logic [20:0] cp);
        int          tail;
        int          k;
        logic [7:0]  lead;
        logic [20:0] sh;
        if (cp < 21'h80) begin
            tail = 0;
            lead = cp[7:0];
        end else if (cp < 21'h800) begin
            tail = 1;
            lead = 8'hC0 | {3'b000, cp[10:6]};
        end else if (cp < 21'h10000) begin
            tail = 2;
            lead = 8'hE0 | {4'b0000, cp[15:12]};
        end else begin
            tail = 3;
            lead = 8'hF0 | {5'b00000, cp[20:18]};
        end
        add_cp_byte(lead);
        for (k = tail - 1; k >= 0; k--) begin
            sh = cp >> (6 * k);
            add_cp_byte({2'b10, sh[5:0]});
        end
    endtask

    // Emit a waiting high surrogate as a three-byte sequence
    task automatic flush_high();
        if (hi_ok) begin
            emit_cp({5'd0, SUR_HI_MIN | {6'd0, hi_sur}});
            hi_ok  = 1'b0;
            hi_sur = 10'h000;
        end
    endtask

    // Handle one UTF-16 unit with surrogate pairing
    task automatic take_unit(input logic [15:0] u);
        logic paired;
        paired = 1'b0;
        if (hi_ok) begin
            if (u >= SUR_LO_MIN && u <= SUR_LO_MAX) begin
                emit_cp(SUPP_BASE + {1'b0, hi_sur, u[9:0]});
                hi_ok  = 1'b0;
                hi_sur = 10'h000;
                paired = 1'b1;
            end else begin
                flush_high();
            end
        end
        if (!paired) begin
            if (u >= SUR_HI_MIN && u <= SUR_HI_MAX) begin
                hi_sur = u[9:0];
                hi_ok  = 1'b1;
            end else begin
                emit_cp({5'd0, u});
            end
        end
    endtask

    // Predict the output transfers caused by one accepted string byte
    task automatic transcode_byte(input logic [7:0] b, input logic fin);
        t_utf8_beat beat;
        int         k;
        cp_bytes_q.delete();
        case (dec_phase)
            PH_FIRST: begin
                if (fin) begin
                    emit_cp({13'd0, b});
                end else begin
                    held_b    = b;
                    held_ok   = 1'b1;
                    dec_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                if (held_b == C_BOM_HI && b == C_BOM_LO) begin
                    dec_phase = PH_WIDE;
                end else begin
                    emit_cp({13'd0, held_b});
                    emit_cp({13'd0, b});
                    dec_phase = PH_NARROW;
                end
                held_b  = 8'h00;
                held_ok = 1'b0;
            end
            PH_WIDE: begin
                if (held_ok) begin
                    held_ok = 1'b0;
                    take_unit({held_b, b});
                    held_b  = 8'h00;
                end else begin
                    held_b  = b;
                    held_ok = 1'b1;
                end
                if (fin)
                    flush_high();
            end
            default: emit_cp({13'd0, b});
        endcase

        // An end that yields nothing still closes with a marker transfer
        if (fin && cp_bytes_q.size() == 0) begin
            beat.data = 8'h00;
            beat.ok   = 1'b0;
            beat.last = 1'b1;
            beat.done = 1'b1;
            add_beat(beat);
        end else begin
            for (k = 0; k < cp_bytes_q.size(); k++) begin
                beat.data = cp_bytes_q[k];
                beat.ok   = 1'b1;
                beat.last = (k == cp_bytes_q.size() - 1);
                beat.done = fin && beat.last;
                add_beat(beat);
            end
        end
        if (fin)
            clear_decoder();
    endtask

    // Present string bytes; hold each until its transfer completes
    always @(negedge i_clk) begin : drive_text
        logic free;
        logic idle;
        free = !s_valid || in_taken;
        idle = !(in_count >= CalmFrom && in_count < CalmTo) && ($urandom_range(0, 99) < 14);
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (free) begin
            if (text_bytes_q.size() > 0 && !idle
                    && !(text_bytes_q[0].sync && utf8_due_q.size() != 0)) begin
                s_data  <= text_bytes_q[0].data;
                s_last  <= text_bytes_q[0].fin;
                s_valid <= 1'b1;
                void'(text_bytes_q.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Accept output bytes with random stalls and one long hold-off
    always @(negedge i_clk) begin : drain_utf8
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else if (!hold_used && in_count >= HoldOffAt) begin
            hold_used <= 1'b1;
            hold_cnt  <= HoldOffLen - 1;
            m_ready   <= 1'b0;
        end else if (in_count >= CalmFrom && in_count < CalmTo) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 14);
        end
    end

    // Predict on each input transfer, compare each output transfer
    always @(posedge i_clk) begin : check_utf8
        t_utf8_beat want;
        in_taken <= in_fire;
        if (!i_rst_n) begin
            clear_decoder();
            utf8_due_q.delete();
        end else begin
            if (in_fire) begin
                transcode_byte(s_data, s_last);
                in_count <= in_count + 1;
            end
            if (out_fire) begin
                out_count <= out_count + 1;
                if (utf8_due_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with none expected, byte %02h",
                                              out_count, m_data));
                end else begin
                    want = utf8_due_q.pop_front();
                    if (m_data !== want.data)
                        report_mismatch($sformatf("result %0d out_byte %02h, want %02h",
                                                  out_count, m_data, want.data));
                    if (m_user[0] !== want.ok)
                        report_mismatch($sformatf("result %0d byte_valid %b, want %b",
                                                  out_count, m_user[0], want.ok));
                    if (m_user[1] !== want.last)
                        report_mismatch($sformatf("result %0d run_last %b, want %b",
                                                  out_count, m_user[1], want.last));
                    if (m_last !== want.done)
                        report_mismatch($sformatf("result %0d string_done %b, want %b",
                                                  out_count, m_last, want.done));
                end
            end
        end
    end

    // End the run when neither side moves for too long
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || in_fire || out_fire) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          k;
        int          len;
        int          first_random;
        logic        mid_synced;
        logic [15:0] u;

        // Single-byte strings at both ends of the byte range
        put_text(8'h00, 1'b1);
        put_text(8'hFF, 1'b1);
        // FE not followed by FF stays one byte per code point
        put_text(C_BOM_HI, 1'b0);
        put_text(8'h41, 1'b1);
        // Mark alone: nothing to send, closes with the empty marker
        put_text(C_BOM_HI, 1'b0);
        put_text(C_BOM_LO, 1'b1);
        // UTF-16 text through every encoded length and surrogate case
        put_text(C_BOM_HI, 1'b0);
        put_text(C_BOM_LO, 1'b0);
        put_unit(16'h007F);
        put_unit(16'h07FF);
        put_unit(16'hFFFF);
        put_unit(16'hD800);     // high surrogate left unpaired by
        put_unit(16'hE000);     // a three-byte unit: six results at once
        put_unit(16'hDBFF);
        put_unit(16'hDFFF);     // highest supplementary code point
        put_unit(16'hDC00);     // lone low surrogate
        put_unit(16'hD800);
        put_text(8'h41, 1'b1);  // odd byte dropped, high surrogate flushed

        // Random strings: mostly well-formed, some raw noise
        first_random = text_bytes_q.size();
        mid_synced   = 1'b0;
        sync_next    = 1'b1;
        while (text_bytes_q.size() < first_random + RandomItems) begin
            if (!mid_synced && text_bytes_q.size() > first_random + RandomItems / 2) begin
                sync_next  = 1'b1;
                mid_synced = 1'b1;
            end
            raw_q.delete();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    add_raw(C_BOM_HI);
                    add_raw(C_BOM_LO);
                    len = $urandom_range(0, 6);
                    for (k = 0; k < len; k++) begin
                        case ($urandom_range(0, 9))
                            0, 1: u = 16'($urandom_range(16'h0000, 16'h007F));
                            2:    u = 16'($urandom_range(16'h0080, 16'h07FF));
                            3:    u = 16'($urandom_range(16'h0000, 16'hFFFF));
                            4, 5: u = 16'($urandom_range(SUR_HI_MIN, SUR_HI_MAX));
                            6:    u = 16'($urandom_range(SUR_LO_MIN, SUR_LO_MAX));
                            7:    u = 16'($urandom_range(16'hE000, 16'hFFFF));
                            default: begin
                                u = 16'($urandom_range(SUR_HI_MIN, SUR_HI_MAX));
                                add_raw(u[15:8]);
                                add_raw(u[7:0]);
                                u = 16'($urandom_range(SUR_LO_MIN, SUR_LO_MAX));
                            end
                        endcase
                        add_raw(u[15:8]);
                        add_raw(u[7:0]);
                    end
                    if ($urandom_range(0, 3) == 0)
                        add_raw(8'($urandom_range(0, 255)));
                end
                6, 7, 8: begin
                    len = $urandom_range(1, 8);
                    for (k = 0; k < len; k++)
                        add_raw(8'($urandom_range(0, 255)));
                end
                default: begin
                    // Broken text: maybe a mark, then up to nine raw bytes
                    if ($urandom_range(0, 1) == 1) begin
                        add_raw(C_BOM_HI);
                        add_raw(C_BOM_LO);
                    end
                    len = $urandom_range(0, 9);
                    for (k = 0; k < len; k++)
                        add_raw(8'($urandom_range(0, 255)));
                    if (raw_q.size() == 0)
                        add_raw(8'($urandom_range(0, 255)));
                end
            endcase
            for (k = 0; k < raw_q.size(); k++)
                put_text(raw_q[k], k == raw_q.size() - 1);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all bytes to go in and all results to come out
        while (text_bytes_q.size() != 0 || s_valid)
            @(posedge i_clk);
        while (utf8_due_q.size() != 0)
            @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
